// File: rtl/core/grid_cell_point_dedup_top_macros.svh
// ----------------------------------------------------------------------------
// grid_cell_point_dedup_top_macros.svh
// Assertion macros shared by the grid cell dedup block
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_POINT_DEDUP_TOP_MACROS_SVH
`define GRID_CELL_POINT_DEDUP_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GCPD_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("gcpd: implication violated");

// next-cycle implication, sampled on clk, off during reset
`define GCPD_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("gcpd: next-cycle implication violated");

`endif

// File: rtl/core/gcpd_pkg.sv
// ----------------------------------------------------------------------------
// gcpd_pkg
// Widths, constants and shared types of the grid cell point dedup block
// ----------------------------------------------------------------------------
package gcpd_pkg;

    // field widths
    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int RW_W   = 13;
    localparam int CFG_W  = 29;

    // cell rounding: (offset + half cell) / cell, truncating toward zero
    localparam int DIV_W   = 31;
    localparam int QMAG_W  = 15;
    localparam int Q_W     = 16;
    localparam int CONST_W = 17;
    localparam logic [CONST_W-1:0] CELL_MICRO      = 17'd100000;
    localparam logic [CONST_W-1:0] HALF_CELL_MICRO = 17'd50000;

    // reciprocal of the cell size, scaled by 2^RECIP_SHIFT and rounded down
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 40;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10995116;
    localparam int BACK_W = QMAG_W + CONST_W;

    // cell index arithmetic
    localparam int PROD_W = Q_W + RW_W + 1;
    localparam int IDX_W  = PROD_W + 1;
    localparam int GRID_W = 2 * RW_W;

    // bitmap store organized as lines of cells
    localparam int CELL_AW    = 20;
    localparam int MAX_CELLS  = 1 << CELL_AW;
    localparam int LINE_SEL_W = 6;
    localparam int LINE_BITS  = 1 << LINE_SEL_W;
    localparam int LINE_AW    = CELL_AW - LINE_SEL_W;
    localparam int LINES      = 1 << LINE_AW;

    // address pipeline depth: offset, four divider stages, multiply, index
    localparam int CELL_STAGES = 7;

    // configuration reset values
    localparam logic signed [LAT_W-1:0] MIN_LAT_RST = -28'sd90000000;
    localparam logic signed [LON_W-1:0] MIN_LON_RST = -29'sd180000000;
    localparam logic [RW_W-1:0]         ROW_W_RST   = 13'd3610;
    localparam logic [RW_W-1:0]         ROW_C_RST   = 13'd1810;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN_LAT   = 2'd0,
        REG_MIN_LON   = 2'd1,
        REG_ROW_WIDTH = 2'd2,
        REG_ROW_COUNT = 2'd3
    } gcpd_reg_t;

    // cell lookup request from the address pipeline to the bitmap
    typedef struct packed {
        logic               valid;
        logic               flag;
        logic [CELL_AW-1:0] index;
    } gcpd_req_t;

    // test-and-set outcome from the bitmap
    typedef struct packed {
        logic               valid;
        logic               is_new;
        logic               out_of_grid;
        logic [CELL_AW-1:0] cell_index;
    } gcpd_res_t;

    // bitmap status
    typedef struct packed {
        logic busy;
    } gcpd_stat_t;

endpackage

// File: rtl/core/gcpd_div.sv
// ----------------------------------------------------------------------------
// gcpd_div
// Four-stage signed divide by the cell size, truncating toward zero
// ----------------------------------------------------------------------------
module gcpd_div (
    input  logic                               clk,
    input  logic                               advance,
    input  logic signed [gcpd_pkg::DIV_W-1:0]  num,
    output logic signed [gcpd_pkg::Q_W-1:0]    quo
);
    import gcpd_pkg::*;

    logic                              neg1_reg;
    logic [DIV_W-1:0]                  mag1_reg;
    logic [DIV_W-1:0]                  mag1_next;
    logic                              neg2_reg;
    logic [DIV_W-1:0]                  mag2_reg;
    logic [QMAG_W-1:0]                 est2_reg;
    logic [QMAG_W-1:0]                 est2_next;
    logic [DIV_W+RECIP_W-1:0]          est_prod;
    logic                              neg3_reg;
    logic [DIV_W-1:0]                  mag3_reg;
    logic [QMAG_W-1:0]                 est3_reg;
    logic [BACK_W-1:0]                 back3_reg;
    logic [BACK_W-1:0]                 back3_next;
    logic [BACK_W-1:0]                 rem;
    logic [QMAG_W-1:0]                 qmag;
    logic signed [Q_W-1:0]             quo_reg;
    logic signed [Q_W-1:0]             quo_next;

    // magnitude of the dividend
    always_comb
    begin
        if (num[DIV_W-1])
            mag1_next = DIV_W'(-num);
        else
            mag1_next = DIV_W'(num);
    end

    // quotient estimate by reciprocal multiply, low by at most one
    always_comb
    begin
        est_prod  = {{RECIP_W{1'b0}}, mag1_reg} * {{DIV_W{1'b0}}, RECIP};
        est2_next = est_prod[RECIP_SHIFT +: QMAG_W];
    end

    // estimate scaled back to micro-degrees
    always_comb
    begin
        back3_next = {{CONST_W{1'b0}}, est2_reg} * {{QMAG_W{1'b0}}, CELL_MICRO};
    end

    // remainder check, correction and sign
    always_comb
    begin
        rem = {{(BACK_W-DIV_W){1'b0}}, mag3_reg} - back3_reg;
        if (rem >= {{(BACK_W-CONST_W){1'b0}}, CELL_MICRO})
            qmag = est3_reg + QMAG_W'(1);
        else
            qmag = est3_reg;
        if (neg3_reg)
            quo_next = -$signed({1'b0, qmag});
        else
            quo_next = $signed({1'b0, qmag});
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg1_reg  <= num[DIV_W-1];
            mag1_reg  <= mag1_next;
            neg2_reg  <= neg1_reg;
            mag2_reg  <= mag1_reg;
            est2_reg  <= est2_next;
            neg3_reg  <= neg2_reg;
            mag3_reg  <= mag2_reg;
            est3_reg  <= est2_reg;
            back3_reg <= back3_next;
            quo_reg   <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// File: rtl/core/gcpd_cell.sv
// ----------------------------------------------------------------------------
// gcpd_cell
// Address pipeline: offsets, cell rounding, row-major index and range check
// ----------------------------------------------------------------------------
module gcpd_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               in_fire,
    input  logic signed [gcpd_pkg::LAT_W-1:0]  lat_micro,
    input  logic signed [gcpd_pkg::LON_W-1:0]  lon_micro,
    input  logic signed [gcpd_pkg::LAT_W-1:0]  min_lat,
    input  logic signed [gcpd_pkg::LON_W-1:0]  min_lon,
    input  logic [gcpd_pkg::RW_W-1:0]          row_width,
    input  logic [gcpd_pkg::GRID_W-1:0]        grid,
    output gcpd_pkg::gcpd_req_t                req
);
    import gcpd_pkg::*;

    logic [CELL_STAGES-1:0]     vld_reg;
    logic signed [DIV_W-1:0]    lat_sum_reg;
    logic signed [DIV_W-1:0]    lat_sum_next;
    logic signed [DIV_W-1:0]    lon_sum_reg;
    logic signed [DIV_W-1:0]    lon_sum_next;
    logic signed [Q_W-1:0]      row_q;
    logic signed [Q_W-1:0]      col_q;
    logic signed [PROD_W-1:0]   row_prod_reg;
    logic signed [PROD_W-1:0]   row_prod_next;
    logic signed [Q_W-1:0]      col_reg;
    logic signed [IDX_W-1:0]    idx;
    logic                       flag_next;
    logic                       flag_reg;
    logic [CELL_AW-1:0]         index_next;
    logic [CELL_AW-1:0]         index_reg;

    // offsets from the grid origin plus half a cell
    always_comb
    begin
        lat_sum_next = {{(DIV_W-LAT_W){lat_micro[LAT_W-1]}}, lat_micro}
                     - {{(DIV_W-LAT_W){min_lat[LAT_W-1]}}, min_lat}
                     + $signed({{(DIV_W-CONST_W){1'b0}}, HALF_CELL_MICRO});
        lon_sum_next = {{(DIV_W-LON_W){lon_micro[LON_W-1]}}, lon_micro}
                     - {{(DIV_W-LON_W){min_lon[LON_W-1]}}, min_lon}
                     + $signed({{(DIV_W-CONST_W){1'b0}}, HALF_CELL_MICRO});
    end

    // row and column rounding
    gcpd_div u_row_div (
        .clk     (clk),
        .advance (advance),
        .num     (lat_sum_reg),
        .quo     (row_q)
    );

    gcpd_div u_col_div (
        .clk     (clk),
        .advance (advance),
        .num     (lon_sum_reg),
        .quo     (col_q)
    );

    // row times row width
    always_comb
    begin
        row_prod_next = PROD_W'(row_q * $signed({1'b0, row_width}));
    end

    // final index and range check against grid and store size
    always_comb
    begin
        idx = {{(IDX_W-PROD_W){row_prod_reg[PROD_W-1]}}, row_prod_reg}
            + {{(IDX_W-Q_W){col_reg[Q_W-1]}}, col_reg};
        flag_next = idx[IDX_W-1]
                 || (idx[IDX_W-2:0] >= {{(IDX_W-1-GRID_W){1'b0}}, grid})
                 || (idx[IDX_W-2:CELL_AW] != '0);
        if (flag_next)
            index_next = '0;
        else
            index_next = idx[CELL_AW-1:0];
    end

    // transaction valid tracking through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[CELL_STAGES-2:0], in_fire};
    end

    // payload stage registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lat_sum_reg  <= lat_sum_next;
            lon_sum_reg  <= lon_sum_next;
            row_prod_reg <= row_prod_next;
            col_reg      <= col_q;
            flag_reg     <= flag_next;
            index_reg    <= index_next;
        end
    end

    assign req.valid = vld_reg[CELL_STAGES-1];
    assign req.flag  = flag_reg;
    assign req.index = index_reg;

endmodule

// File: rtl/core/gcpd_bitmap.sv
// ----------------------------------------------------------------------------
// gcpd_bitmap
// Occupancy bitmap in line memory with read-modify-write and forwarding
// ----------------------------------------------------------------------------
module gcpd_bitmap (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  gcpd_pkg::gcpd_req_t   req,
    output gcpd_pkg::gcpd_res_t   res,
    output gcpd_pkg::gcpd_stat_t  stat
);
    import gcpd_pkg::*;

    logic [LINE_BITS-1:0]   mem [LINES];
    logic [LINE_BITS-1:0]   rd_data_reg;
    gcpd_req_t              b_req_reg;
    logic                   clr_busy_reg;
    logic                   clr_busy_next;
    logic [LINE_AW-1:0]     clr_addr_reg;
    logic [LINE_AW-1:0]     clr_addr_next;
    logic                   fwd_vld_reg;
    logic                   fwd_vld_next;
    logic [LINE_AW-1:0]     fwd_addr_reg;
    logic [LINE_BITS-1:0]   fwd_data_reg;
    logic [LINE_AW-1:0]     b_line;
    logic [LINE_SEL_W-1:0]  b_sel;
    logic [LINE_BITS-1:0]   line_now;
    logic [LINE_BITS-1:0]   line_new;
    logic                   was_set;
    logic                   rmw_we;
    logic                   wr_en;
    logic [LINE_AW-1:0]     wr_addr;
    logic [LINE_BITS-1:0]   wr_data;

    // modify: merge the last write when it hit the line being read
    always_comb
    begin
        b_line = b_req_reg.index[CELL_AW-1:LINE_SEL_W];
        b_sel  = b_req_reg.index[LINE_SEL_W-1:0];
        if (fwd_vld_reg && (fwd_addr_reg == b_line))
            line_now = fwd_data_reg;
        else
            line_now = rd_data_reg;
        was_set  = line_now[b_sel];
        line_new = line_now | (LINE_BITS'(1) << b_sel);
        rmw_we   = advance && b_req_reg.valid && !b_req_reg.flag;
    end

    // write port: clearing pass first, then marks
    always_comb
    begin
        wr_en = clr_busy_reg || rmw_we;
        if (clr_busy_reg)
        begin
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_addr = b_line;
            wr_data = line_new;
        end
    end

    // clearing pass sequencing
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + LINE_AW'(1);
            if (clr_addr_reg == '1)
                clr_busy_next = 1'b0;
        end
    end

    // forwarding entry tracks the most recent mark
    always_comb
    begin
        fwd_vld_next = fwd_vld_reg;
        if (clr_busy_reg)
            fwd_vld_next = 1'b0;
        else if (rmw_we)
            fwd_vld_next = 1'b1;
    end

    // line memory, synchronous read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (advance)
            rd_data_reg <= mem[req.index[CELL_AW-1:LINE_SEL_W]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            fwd_vld_reg  <= 1'b0;
            b_req_reg    <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            fwd_vld_reg  <= fwd_vld_next;
            if (advance)
                b_req_reg <= req;
        end
    end

    // forwarding payload
    always_ff @(posedge clk)
    begin
        if (rmw_we)
        begin
            fwd_addr_reg <= b_line;
            fwd_data_reg <= line_new;
        end
    end

    assign res.valid       = b_req_reg.valid;
    assign res.is_new      = !b_req_reg.flag && !was_set;
    assign res.out_of_grid = b_req_reg.flag;
    assign res.cell_index  = b_req_reg.index;
    assign stat.busy       = clr_busy_reg;

endmodule

// File: rtl/core/grid_cell_point_dedup_top.sv
// A result leaves through the address pipeline, the bitmap stage and the output register.
// Throughput: one point per cycle unless stalled; the line memory does one read and one
// write per cycle. Back-to-back points in the same 64-cell line are served by write
// forwarding. Reset clears configuration to defaults, then a clearing pass over all 16384
// lines zeroes the bitmap one line per cycle while input is stalled.
// ----------------------------------------------------------------------------
// grid_cell_point_dedup_top
// Tenth-degree grid cell test-and-set for streamed geographic points
// ----------------------------------------------------------------------------
`include "grid_cell_point_dedup_top_macros.svh"

module grid_cell_point_dedup_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gcpd_pkg::LAT_W-1:0]   lat_micro,
    input  logic signed [gcpd_pkg::LON_W-1:0]   lon_micro,
    input  logic                                cfg_we,
    input  gcpd_pkg::gcpd_reg_t                 cfg_index,
    input  logic [gcpd_pkg::CFG_W-1:0]          cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_new,
    output logic                                out_of_grid,
    output logic [gcpd_pkg::CELL_AW-1:0]        cell_index
);
    import gcpd_pkg::*;

    logic signed [LAT_W-1:0]  min_lat_reg;
    logic signed [LON_W-1:0]  min_lon_reg;
    logic [RW_W-1:0]          row_width_reg;
    logic [RW_W-1:0]          row_count_reg;
    logic [GRID_W-1:0]        grid_reg;
    logic                     advance;
    logic                     in_fire;
    gcpd_req_t                req;
    gcpd_res_t                res;
    gcpd_stat_t               stat;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     is_new_reg;
    logic                     out_of_grid_reg;
    logic [CELL_AW-1:0]       cell_index_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_lat_reg   <= MIN_LAT_RST;
            min_lon_reg   <= MIN_LON_RST;
            row_width_reg <= ROW_W_RST;
            row_count_reg <= ROW_C_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LAT:   min_lat_reg   <= cfg_data[LAT_W-1:0];
                REG_MIN_LON:   min_lon_reg   <= cfg_data[LON_W-1:0];
                REG_ROW_WIDTH: row_width_reg <= cfg_data[RW_W-1:0];
                REG_ROW_COUNT: row_count_reg <= cfg_data[RW_W-1:0];
                default:       ;
            endcase
        end
    end

    // grid size follows the configuration
    always_ff @(posedge clk)
    begin
        grid_reg <= {{RW_W{1'b0}}, row_width_reg} * {{RW_W{1'b0}}, row_count_reg};
    end

    // pipeline moves unless a finished result is blocked behind the output
    always_comb
    begin
        advance  = !(out_valid_reg && out_stall && res.valid);
        in_stall = stat.busy || !advance;
        in_fire  = in_valid && !in_stall;
    end

    gcpd_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_fire   (in_fire),
        .lat_micro (lat_micro),
        .lon_micro (lon_micro),
        .min_lat   (min_lat_reg),
        .min_lon   (min_lon_reg),
        .row_width (row_width_reg),
        .grid      (grid_reg),
        .req       (req)
    );

    gcpd_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req),
        .res     (res),
        .stat    (stat)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res.valid)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            is_new_reg      <= res.is_new;
            out_of_grid_reg <= res.out_of_grid;
            cell_index_reg  <= res.cell_index;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_new      = is_new_reg;
    assign out_of_grid = out_of_grid_reg;
    assign cell_index  = cell_index_reg;

    // flagged points never mark and report index zero
    `GCPD_ASSERT_IMP(a_flag_clean, out_valid && out_of_grid, !is_new && cell_index == '0)
    // same cell twice in a row: forwarding must show the first mark
    `GCPD_ASSERT_IMP(a_fwd_repeat, (out_valid && !out_stall && !out_of_grid) ##1 (out_valid && !out_stall && !out_of_grid && cell_index == $past(cell_index)), !is_new)
    // no result can form while the bitmap is being cleared
    `GCPD_ASSERT_NXT(a_clear_quiet, stat.busy, !out_valid)

endmodule

// File: test/grid_cell_dedup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_dedup_checker
// Watches the point and result channels of the grid cell dedup block, keeps
// its own configuration and occupancy bitmap, works out the expected verdict
// for every accepted point and compares each accepted result in order
// ----------------------------------------------------------------------------
module grid_cell_dedup_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [gcpd_pkg::LAT_W-1:0]  lat_micro,
    input  logic signed [gcpd_pkg::LON_W-1:0]  lon_micro,
    input  logic                               cfg_we,
    input  gcpd_pkg::gcpd_reg_t                cfg_index,
    input  logic [gcpd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               is_new,
    input  logic                               out_of_grid,
    input  logic [gcpd_pkg::CELL_AW-1:0]       cell_index,
    output int                                 fail_count,
    output int                                 outstanding,
    output int                                 new_seen,
    output int                                 dup_seen,
    output int                                 flagged_seen
);
    import gcpd_pkg::*;

    localparam longint HALF_CELL  = 50000;
    localparam longint CELL_SPAN  = 100000;

    // expected verdict for one point
    typedef struct packed {
        logic               is_new;
        logic               out_of_grid;
        logic [CELL_AW-1:0] cell_index;
    } cell_verdict_t;

    cell_verdict_t      verdict_q[$];
    logic [LINE_BITS-1:0] occ_line [LINES];

    // shadow of the grid registers
    longint             lat_origin;
    longint             lon_origin;
    logic [RW_W-1:0]    cols_per_row;
    logic [RW_W-1:0]    row_total;

    int mismatches;
    int n_new;
    int n_dup;
    int n_flagged;

    // one line per mismatch, each one counted
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // round a point to its cell, then test and set that cell in the bitmap
    function automatic cell_verdict_t test_and_set_cell(
        input logic signed [LAT_W-1:0] lat,
        input logic signed [LON_W-1:0] lon
    );
        cell_verdict_t v;
        longint row;
        longint col;
        longint idx;
        longint cells;
        logic [CELL_AW-1:0] cell_idx;
        row   = (longint'(lat) - lat_origin + HALF_CELL) / CELL_SPAN;
        col   = (longint'(lon) - lon_origin + HALF_CELL) / CELL_SPAN;
        idx   = row * longint'(cols_per_row) + col;
        cells = longint'(cols_per_row) * longint'(row_total);
        if (idx < 0 || idx >= cells || idx >= longint'(MAX_CELLS))
        begin
            v.is_new      = 1'b0;
            v.out_of_grid = 1'b1;
            v.cell_index  = '0;
        end
        else
        begin
            cell_idx      = idx[CELL_AW-1:0];
            v.is_new      = !occ_line[cell_idx[CELL_AW-1:LINE_SEL_W]][cell_idx[LINE_SEL_W-1:0]];
            v.out_of_grid = 1'b0;
            v.cell_index  = cell_idx;
            occ_line[cell_idx[CELL_AW-1:LINE_SEL_W]][cell_idx[LINE_SEL_W-1:0]] = 1'b1;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_verdict_t want;
        if (!rst_n)
        begin
            verdict_q.delete();
            for (int i = 0; i < LINES; i++)
                occ_line[i] = '0;
            lat_origin   = longint'(MIN_LAT_RST);
            lon_origin   = longint'(MIN_LON_RST);
            cols_per_row = ROW_W_RST;
            row_total    = ROW_C_RST;
            mismatches   = 0;
            n_new        = 0;
            n_dup        = 0;
            n_flagged    = 0;
            fail_count   <= 0;
            outstanding  <= 0;
            new_seen     <= 0;
            dup_seen     <= 0;
            flagged_seen <= 0;
        end
        else
        begin
            // result transaction against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("result with no point pending, cell_index",
                                    longint'(cell_index), longint'(0));
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (is_new !== want.is_new)
                        report_mismatch("is_new", longint'(is_new), longint'(want.is_new));
                    if (out_of_grid !== want.out_of_grid)
                        report_mismatch("out_of_grid", longint'(out_of_grid),
                                        longint'(want.out_of_grid));
                    if (cell_index !== want.cell_index)
                        report_mismatch("cell_index", longint'(cell_index),
                                        longint'(want.cell_index));
                end
                if (out_of_grid)
                    n_flagged++;
                else if (is_new)
                    n_new++;
                else
                    n_dup++;
            end

            // point transaction
            if (in_valid && !in_stall)
                verdict_q = {verdict_q, test_and_set_cell(lat_micro, lon_micro)};

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_LAT:   lat_origin   = longint'($signed(cfg_data[LAT_W-1:0]));
                    REG_MIN_LON:   lon_origin   = longint'($signed(cfg_data[LON_W-1:0]));
                    REG_ROW_WIDTH: cols_per_row = cfg_data[RW_W-1:0];
                    REG_ROW_COUNT: row_total    = cfg_data[RW_W-1:0];
                    default: ;
                endcase
            end

            fail_count   <= mismatches;
            outstanding  <= verdict_q.size();
            new_seen     <= n_new;
            dup_seen     <= n_dup;
            flagged_seen <= n_flagged;
        end
    end

endmodule

// File: test/tb_grid_cell_point_dedup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_cell_point_dedup_top
// Streams geographic points into the grid cell dedup block under several
// grid settings, with random gaps and stalls on both channels; the checker
// beside the block predicts each verdict and this top gives the final word
// ----------------------------------------------------------------------------
module tb_grid_cell_point_dedup_top;
    import gcpd_pkg::*;

    localparam longint HALF_CELL    = 50000;
    localparam longint CELL_SPAN    = 100000;
    localparam int     LIMIT_CYCLES = 200000;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     SETTLE       = 12;
    localparam int     RECENT_N     = 8;

    // default grid origin
    localparam longint LAT0 = -90000000;
    localparam longint LON0 = -180000000;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic signed [LAT_W-1:0] lat_micro   = '0;
    logic signed [LON_W-1:0] lon_micro   = '0;
    logic                    cfg_we      = 1'b0;
    gcpd_reg_t               cfg_index   = REG_MIN_LAT;
    logic [CFG_W-1:0]        cfg_data    = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic                    is_new;
    logic                    out_of_grid;
    logic [CELL_AW-1:0]      cell_index;

    int fail_count;
    int outstanding;
    int new_seen;
    int dup_seen;
    int flagged_seen;

    // stimulus-side view of the grid, used to aim points
    longint grid_lat0 = LAT0;
    longint grid_lon0 = LON0;
    longint grid_cols = 3610;
    longint grid_rows = 1810;

    int          send_idle_pct  = 20;
    int          recv_stall_pct = 20;
    bit          hold_req       = 1'b0;
    int          points_sent    = 0;
    int          settings_used  = 1;
    int unsigned cycle_count    = 0;

    longint recent_lat [RECENT_N];
    longint recent_lon [RECENT_N];
    int     recent_cnt = 0;
    int     recent_wr  = 0;

    grid_cell_point_dedup_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .lat_micro   (lat_micro),
        .lon_micro   (lon_micro),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_new      (is_new),
        .out_of_grid (out_of_grid),
        .cell_index  (cell_index)
    );

    grid_cell_dedup_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .lat_micro    (lat_micro),
        .lon_micro    (lon_micro),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_new       (is_new),
        .out_of_grid  (out_of_grid),
        .cell_index   (cell_index),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .new_seen     (new_seen),
        .dup_seen     (dup_seen),
        .flagged_seen (flagged_seen)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles with %0d results pending", cycle_count,
                     outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // offer one point transaction after a random gap, wait for acceptance
    task automatic send_point(input longint lat, input longint lon);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        lat_micro <= lat[LAT_W-1:0];
        lon_micro <= lon[LON_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        recent_lat[recent_wr] = lat;
        recent_lon[recent_wr] = lon;
        recent_wr = (recent_wr + 1) % RECENT_N;
        if (recent_cnt < RECENT_N)
            recent_cnt++;
        points_sent++;
    endtask

    // stop offering and wait until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // mostly points aimed inside the grid, with revisits, line neighbors and noise
    task automatic pick_point(output longint lat, output longint lon);
        int unsigned sel;
        int          k;
        longint      span_r;
        longint      span_c;
        longint      r;
        longint      c;
        sel = $urandom_range(0, 99);
        k   = (recent_cnt > 0) ? $urandom_range(0, recent_cnt - 1) : 0;
        if (sel < 15)
        begin
            lat = longint'($urandom);
            lon = longint'($urandom);
        end
        else if (sel < 30 && recent_cnt > 0)
        begin
            lat = recent_lat[k];
            lon = recent_lon[k];
        end
        else if (sel < 40 && recent_cnt > 0)
        begin
            lat = recent_lat[k];
            lon = recent_lon[k] + CELL_SPAN;
        end
        else
        begin
            // columns run a little past the row width so some indexes wrap
            span_c = (grid_cols == 0) ? 4 : grid_cols + grid_cols / 4 + 1;
            span_r = (grid_rows == 0) ? 4 : grid_rows;
            if (grid_cols != 0 && span_r > longint'(MAX_CELLS) / grid_cols + 2)
                span_r = longint'(MAX_CELLS) / grid_cols + 2;
            r = longint'($urandom_range(0, int'(span_r - 1)));
            c = longint'($urandom_range(0, int'(span_c - 1)));
            if ($urandom_range(0, 19) == 0)
                r = -1;
            if ($urandom_range(0, 19) == 0)
                c = -1;
            lat = grid_lat0 + r * CELL_SPAN + longint'($urandom_range(0, 99999)) - HALF_CELL;
            lon = grid_lon0 + c * CELL_SPAN + longint'($urandom_range(0, 99999)) - HALF_CELL;
        end
    endtask

    // new grid setting once idle, then a burst of random points
    task automatic run_grid_phase(input longint lat0, input longint lon0, input int cols,
                                  input int rows, input int items, input int idle_pct,
                                  input bit hold);
        longint lat;
        longint lon;
        drain_results();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_LAT;
        cfg_data  <= lat0[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_MIN_LON;
        cfg_data  <= lon0[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_ROW_WIDTH;
        cfg_data  <= CFG_W'(cols);
        @(posedge clk);
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= CFG_W'(rows);
        @(posedge clk);
        cfg_we    <= 1'b0;
        grid_lat0 = longint'($signed(lat0[LAT_W-1:0]));
        grid_lon0 = longint'($signed(lon0[LON_W-1:0]));
        grid_cols = longint'(cols % (1 << RW_W));
        grid_rows = longint'(rows % (1 << RW_W));
        settings_used++;
        send_idle_pct  = idle_pct;
        recv_stall_pct = idle_pct;
        if (hold)
            hold_req = 1'b1;
        repeat (items)
        begin
            pick_point(lat, lon);
            send_point(lat, lon);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed points on the reset grid, first ones wait out the clearing pass
        send_point(LAT0, LON0);                              // first cell
        send_point(LAT0, LON0);                              // same cell again
        send_point(90000000, 180000000);                     // far corner, past the store
        send_point(LAT0 - 49999, LON0);                      // small negative offset, row 0
        send_point(LAT0, LON0 - 150001);                     // column -1, negative index
        send_point(LAT0 - 150001, LON0);                     // row -1, negative index
        send_point(-134217728, -268435456);                  // field minimums
        send_point(134217727, 268435455);                    // field maximums
        send_point(-134217728, 268435455);
        send_point(134217727, -268435456);
        send_point(LAT0, LON0 + 3615 * CELL_SPAN);           // column past row width wraps
        send_point(LAT0 + CELL_SPAN, LON0 + 5 * CELL_SPAN);  // same cell by row and column
        send_point(LAT0, LON0 + 49999);                      // just under the rounding step
        send_point(LAT0, LON0 + 50000);                      // on the rounding step
        send_point(LAT0, LON0 + 2 * CELL_SPAN);              // neighbors within one line
        send_point(LAT0, LON0 + 3 * CELL_SPAN);
        send_point(LAT0, LON0 + 2 * CELL_SPAN);
        send_point(LAT0 + 290 * CELL_SPAN, LON0 + 1675 * CELL_SPAN);  // last cell of store
        send_point(LAT0 + 290 * CELL_SPAN, LON0 + 1676 * CELL_SPAN);  // one past the store
        send_point(LAT0 + 290 * CELL_SPAN, LON0 + 1675 * CELL_SPAN);
        send_point(-80000000, 0);

        // random phases across grid settings, extremes included
        run_grid_phase(10000000, -20000000, 16, 16, 200, 20, 1'b1);
        run_grid_phase(-134217728, 268435455, 1, 4096, 80, 20, 1'b0);
        run_grid_phase(0, 0, 0, 3000, 40, 20, 1'b0);
        run_grid_phase(5000000, 5000000, 8191, 8191, 100, 20, 1'b0);
        run_grid_phase(LAT0, LON0, 3610, 1810, 200, 0, 1'b0);
        run_grid_phase(134217727, -268435456, 4096, 0, 40, 20, 1'b0);
        run_grid_phase(-1000000, 1000000, 64, 40, 200, 20, 1'b1);

        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d points over %0d grid settings, empty and oversized grids included",
                 points_sent, settings_used);
        $display("verdicts: %0d first in cell, %0d repeats, %0d off grid",
                 new_seen, dup_seen, flagged_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/gcpd_pkg.sv
rtl/core/gcpd_div.sv
rtl/core/gcpd_cell.sv
rtl/core/gcpd_bitmap.sv
rtl/core/grid_cell_point_dedup_top.sv
test/grid_cell_dedup_checker.sv
test/tb_grid_cell_point_dedup_top.sv
